@@ hdl/text_console_writer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shorthand for the clocked, reset-qualified checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer: next-cycle check failed");

`endif

@@ hdl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, opcodes and character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

    // Widths
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = ATTR_W + CHAR_W;
    localparam int IDX_W      = 11;
    localparam int POS_W      = 11;

    typedef logic [OP_W-1:0]   opcode_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ATTR_W-1:0] attr_t;
    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;

    // Opcodes
    localparam opcode_t OP_PUT   = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    // Character codes
    localparam char_t CHAR_TAB   = 8'd9;
    localparam char_t CHAR_LF    = 8'd10;
    localparam char_t CHAR_CR    = 8'd13;
    localparam char_t CHAR_SPACE = 8'd32;

    localparam int    TAB_STEP   = 4;
    localparam attr_t RESET_ATTR = 8'd15;

    // Linear cell address of a cursor position
    function automatic addr_t cell_pos(input row_t row, input col_t col);
        return addr_t'(row) * addr_t'(COLUMNS) + addr_t'(col);
    endfunction

endpackage

@@ hdl/tcw_channels.sv @@
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready interfaces for command items, result items and attribute writes.
// ----------------------------------------------------------------------------

// Command item channel
interface tcw_cmd_if;
    logic                      valid;
    logic                      ready;
    tcw_pkg::opcode_t          opcode;
    tcw_pkg::char_t            char_code;
    logic [tcw_pkg::IDX_W-1:0] cell_index;

    modport source (output valid, output opcode, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input opcode, input char_code, input cell_index,
                    output ready);
endinterface

// Result item channel
interface tcw_rsp_if;
    logic                      valid;
    logic                      ready;
    tcw_pkg::cell_t            cell_data;
    logic [tcw_pkg::POS_W-1:0] cursor_position;
    logic                      did_scroll;

    modport source (output valid, output cell_data, output cursor_position,
                    output did_scroll, input ready);
    modport sink   (input valid, input cell_data, input cursor_position,
                    input did_scroll, output ready);
endinterface

// Attribute register write channel
interface tcw_cfg_if;
    logic           valid;
    logic           ready;
    tcw_pkg::attr_t text_attribute;

    modport source (output valid, output text_attribute, input ready);
    modport sink   (input valid, input text_attribute, output ready);
endinterface

@@ hdl/text_console_writer_top.sv @@
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode screen store with cursor, wrap, scroll, clear and cell readback.
// ----------------------------------------------------------------------------
// One item is in work at a time; every item returns one result item. A put
// that does not scroll, a read and an unused opcode go from accept to the
// done state and then into the result register, fed by the registered read
// of the screen memory. A clear and a put that scrolls first pass over every
// cell, since the single write port of the screen memory rewrites one cell per cycle.
// After reset a clearing pass blanks the memory;
// no item is accepted during it, attribute writes are. A new item may be
// accepted while the previous result still waits at the output register.
// ----------------------------------------------------------------------------
module text_console_writer_top (
    input  logic         clk,
    input  logic         rst_n,
    tcw_cmd_if.sink      cmd,
    tcw_rsp_if.source    rsp,
    tcw_cfg_if.sink      cfg
);

    // Sequencer states
    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_SCRL  = 3'd3;
    localparam logic [2:0] ST_LAST  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Screen memory
    tcw_pkg::cell_t mem [tcw_pkg::CELLS];

    logic [2:0]      state_reg, state_next;
    tcw_pkg::addr_t  cnt_reg, cnt_next;
    tcw_pkg::col_t   col_reg, col_next;
    tcw_pkg::row_t   row_reg, row_next;
    tcw_pkg::attr_t  attr_reg, attr_next;
    logic            scroll_reg, scroll_next;
    logic            is_read_reg, is_read_next;
    logic            rd_ok_reg, rd_ok_next;
    logic            pend_valid_reg, pend_valid_next;
    tcw_pkg::addr_t  pend_addr_reg, pend_addr_next;
    logic            pend_blank_reg, pend_blank_next;
    logic            rsp_valid_reg, rsp_valid_next;
    tcw_pkg::cell_t  rsp_data_reg, rsp_data_next;
    logic [tcw_pkg::POS_W-1:0] rsp_pos_reg, rsp_pos_next;
    logic            rsp_scroll_reg, rsp_scroll_next;
    tcw_pkg::cell_t  rd_data_reg;

    logic            wr_en, rd_en;
    tcw_pkg::addr_t  wr_addr, rd_addr;
    tcw_pkg::cell_t  wr_data, blank;
    tcw_pkg::addr_t  cur_pos;
    logic            cmd_fire, rsp_load, idx_ok;
    logic [tcw_pkg::COL_W:0] col_adv;
    logic [tcw_pkg::ROW_W:0] row_adv;
    logic            put_write;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);
    assign blank     = {attr_reg, tcw_pkg::CHAR_SPACE};
    assign cur_pos   = tcw_pkg::cell_pos(row_reg, col_reg);
    assign idx_ok    = (32'(cmd.cell_index) < tcw_pkg::CELLS);

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.cell_data       = rsp_data_reg;
    assign rsp.cursor_position = rsp_pos_reg;
    assign rsp.did_scroll      = rsp_scroll_reg;

    // Cursor movement for a put
    always_comb
    begin
        logic row_step;
        row_step  = 1'b0;
        put_write = 1'b0;
        case (cmd.char_code)
            tcw_pkg::CHAR_CR:
            begin
                col_adv = '0;
            end
            tcw_pkg::CHAR_LF:
            begin
                col_adv  = '0;
                row_step = 1'b1;
            end
            tcw_pkg::CHAR_TAB:
            begin
                col_adv = ({1'b0, col_reg} | (tcw_pkg::COL_W+1)'(tcw_pkg::TAB_STEP - 1))
                          + 1'b1;
            end
            default:
            begin
                col_adv   = {1'b0, col_reg} + 1'b1;
                put_write = 1'b1;
            end
        endcase
        // wrap off the right edge
        if (32'(col_adv) >= tcw_pkg::COLUMNS)
        begin
            col_adv  = '0;
            row_step = 1'b1;
        end
        row_adv = {1'b0, row_reg} + (tcw_pkg::ROW_W+1)'(row_step);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        scroll_next     = scroll_reg;
        is_read_next    = is_read_reg;
        rd_ok_next      = rd_ok_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_blank_next = pend_blank_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg;
        wr_data         = blank;
        rd_en           = 1'b0;
        rd_addr         = cmd.cell_index[tcw_pkg::ADDR_W-1:0];

        // delayed write of the scroll copy pipeline
        if (pend_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = pend_blank_reg ? blank : rd_data_reg;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_data = {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_SPACE};
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == tcw_pkg::CELLS - 1)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    scroll_next  = 1'b0;
                    is_read_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = ST_DONE;
                    case (cmd.opcode)
                        tcw_pkg::OP_PUT:
                        begin
                            if (put_write)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = cur_pos;
                                wr_data = {attr_reg, cmd.char_code};
                            end
                            col_next = col_adv[tcw_pkg::COL_W-1:0];
                            if (32'(row_adv) >= tcw_pkg::ROWS)
                            begin
                                row_next    = tcw_pkg::row_t'(tcw_pkg::ROWS - 1);
                                scroll_next = 1'b1;
                                state_next  = ST_SCRL;
                            end
                            else
                            begin
                                row_next = row_adv[tcw_pkg::ROW_W-1:0];
                            end
                        end
                        tcw_pkg::OP_READ:
                        begin
                            is_read_next = 1'b1;
                            rd_ok_next   = idx_ok;
                            rd_en        = idx_ok;
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            state_next = ST_FILL;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == tcw_pkg::CELLS - 1)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_SCRL:
            begin
                // read one row below (blank for the last row), write back in the next cycle
                pend_valid_next = 1'b1;
                pend_addr_next  = cnt_reg;
                pend_blank_next = (32'(cnt_reg) >= tcw_pkg::COPY_CELLS);
                rd_en           = (32'(cnt_reg) < tcw_pkg::COPY_CELLS);
                rd_addr         = cnt_reg + tcw_pkg::addr_t'(tcw_pkg::COLUMNS);
                cnt_next        = cnt_reg + 1'b1;
                if (32'(cnt_reg) == tcw_pkg::CELLS - 1)
                begin
                    cnt_next   = '0;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Attribute register and result register
    always_comb
    begin
        attr_next = attr_reg;
        if (cfg.valid && cfg.ready)
        begin
            attr_next = cfg.text_attribute;
        end

        rsp_valid_next  = rsp_valid_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_pos_next    = rsp_pos_reg;
        rsp_scroll_next = rsp_scroll_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (rsp_load)
        begin
            rsp_valid_next  = 1'b1;
            rsp_data_next   = (is_read_reg && rd_ok_reg) ? rd_data_reg : '0;
            rsp_pos_next    = tcw_pkg::POS_W'(cur_pos);
            rsp_scroll_next = scroll_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cnt_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            attr_reg       <= tcw_pkg::RESET_ATTR;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            attr_reg       <= attr_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scroll_reg     <= scroll_next;
        is_read_reg    <= is_read_next;
        rd_ok_reg      <= rd_ok_next;
        pend_addr_reg  <= pend_addr_next;
        pend_blank_reg <= pend_blank_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_pos_reg    <= rsp_pos_next;
        rsp_scroll_reg <= rsp_scroll_next;
    end

    // Screen memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// Text console writer port checker
// Checks result consistency and item pacing as seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "text_console_writer_top_defines.svh"

module tcw_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cmd_valid,
    input logic                      cmd_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input tcw_pkg::cell_t            rsp_cell_data,
    input logic [tcw_pkg::POS_W-1:0] rsp_cursor_position,
    input logic                      rsp_did_scroll
);

    // One item in work at a time: no accept right after an accept
    `TCW_ASSERT_NXT(a_one_in_work, cmd_valid && cmd_ready, !cmd_ready)

    // Cursor never leaves the screen
    `TCW_ASSERT_IMP(a_pos_range, rsp_valid,
        32'(rsp_cursor_position) < tcw_pkg::CELLS)

    // A scroll leaves the cursor at the start of the last row
    `TCW_ASSERT_IMP(a_scroll_pos, rsp_valid && rsp_did_scroll,
        32'(rsp_cursor_position) == tcw_pkg::COPY_CELLS)

    // A stalled result holds
    `TCW_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_cell_data) && $stable(rsp_cursor_position)
        && $stable(rsp_did_scroll))

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd.valid),
    .cmd_ready           (cmd.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_cell_data       (rsp.cell_data),
    .rsp_cursor_position (rsp.cursor_position),
    .rsp_did_scroll      (rsp.did_scroll)
);
